// ===== src/slxfr_pkg.sv =====
package slxfr_pkg;

  localparam int unsigned CfgIndexWidth = 3;

  typedef enum logic [CfgIndexWidth-1:0] {
    REG_SYNC_FIRST         = 3'd0,
    REG_SYNC_SECOND        = 3'd1,
    REG_REPLY_MESSAGE_ID   = 3'd2,
    REG_NOTE_MESSAGE_ID    = 3'd3,
    REG_MAX_PAYLOAD_LENGTH = 3'd4
  } cfg_index_t;

  localparam logic [15:0] MaxPayloadLengthReset = 16'd252;

  typedef enum logic [1:0] {
    CLASS_REPLY = 2'd0,
    CLASS_NOTE  = 2'd1,
    CLASS_OTHER = 2'd2
  } frame_class_t;

  typedef enum logic [1:0] {
    STATUS_GOOD = 2'd0,
    STATUS_BAD  = 2'd1,
    STATUS_OVER = 2'd2
  } frame_status_t;

  typedef struct packed {
    logic [7:0]  sync_first;
    logic [7:0]  sync_second;
    logic [7:0]  reply_message_id;
    logic [7:0]  note_message_id;
    logic [15:0] max_payload_length;
  } cfg_t;

  typedef struct packed {
    logic       valid;
    logic [7:0] rx_byte;
  } byte_word_t;

  function automatic frame_class_t class_of(logic [7:0] id, cfg_t cfg);
    frame_class_t c;
    if (id == cfg.reply_message_id) begin
      c = CLASS_REPLY;
    end else if (id == cfg.note_message_id) begin
      c = CLASS_NOTE;
    end else begin
      c = CLASS_OTHER;
    end
    return c;
  endfunction

endpackage

// ===== src/slxfr_if.sv =====
interface slxfr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface slxfr_result_if;
  logic        valid;
  logic        ready;
  logic        is_frame_end;
  logic [7:0]  payload_byte;
  logic [15:0] payload_offset;
  logic [7:0]  message_id;
  logic [1:0]  frame_class;
  logic [1:0]  frame_status;

  modport source (
    output valid, output is_frame_end, output payload_byte, output payload_offset,
    output message_id, output frame_class, output frame_status, input ready
  );
  modport sink (
    input valid, input is_frame_end, input payload_byte, input payload_offset,
    input message_id, input frame_class, input frame_status, output ready
  );
endinterface

interface slxfr_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== src/slxfr_cfg_regs.sv =====
module slxfr_cfg_regs (
  input  logic             clk,
  input  logic             rst,
  slxfr_cfg_if.sink        cfg,
  output slxfr_pkg::cfg_t  regs
);
  import slxfr_pkg::*;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.sync_first         <= 8'd0;
      regs.sync_second        <= 8'd0;
      regs.reply_message_id   <= 8'd0;
      regs.note_message_id    <= 8'd0;
      regs.max_payload_length <= MaxPayloadLengthReset;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_SYNC_FIRST:         regs.sync_first <= cfg.data[7:0];
        REG_SYNC_SECOND:        regs.sync_second <= cfg.data[7:0];
        REG_REPLY_MESSAGE_ID:   regs.reply_message_id <= cfg.data[7:0];
        REG_NOTE_MESSAGE_ID:    regs.note_message_id <= cfg.data[7:0];
        REG_MAX_PAYLOAD_LENGTH: regs.max_payload_length <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/slxfr_in_stage.sv =====
module slxfr_in_stage (
  input  logic                   clk,
  input  logic                   rst,
  slxfr_byte_if.sink             rx,
  input  logic                   take,
  output slxfr_pkg::byte_word_t  word
);
  import slxfr_pkg::*;

  assign rx.ready = !word.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      word.valid <= 1'b0;
    end else if (rx.ready) begin
      word.valid <= rx.valid;
    end
    if (rx.valid && rx.ready) begin
      word.rx_byte <= rx.rx_byte;
    end
  end

endmodule

// ===== src/slxfr_parser.sv =====
module slxfr_parser (
  input  logic                   clk,
  input  logic                   rst,
  input  slxfr_pkg::cfg_t        regs,
  input  slxfr_pkg::byte_word_t  word,
  output logic                   take,
  slxfr_result_if.source         res
);
  import slxfr_pkg::*;

  typedef enum logic [2:0] {
    PH_SYNC1   = 3'd0,
    PH_SYNC2   = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN_HI  = 3'd3,
    PH_LEN_LO  = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_CHECK   = 3'd6
  } phase_t;

  phase_t        phase, phase_next;
  logic [7:0]    held_message_id, held_message_id_next;
  logic [15:0]   expected_length, expected_length_next;
  logic [15:0]   bytes_seen, bytes_seen_next;
  logic [7:0]    running_xor, running_xor_next;
  logic          out_valid_next;
  logic          emit;
  logic          end_flag;
  logic [7:0]    out_byte;
  logic [15:0]   out_offset;
  frame_status_t out_status;
  logic [7:0]    b;
  logic [15:0]   full_length;
  logic [15:0]   seen_inc;

  assign take = word.valid && (!res.valid || res.ready);
  assign b = word.rx_byte;
  assign full_length = {expected_length[15:8], b};
  assign seen_inc = bytes_seen + 16'd1;

  always_comb begin
    phase_next = phase;
    held_message_id_next = held_message_id;
    expected_length_next = expected_length;
    bytes_seen_next = bytes_seen;
    running_xor_next = running_xor;
    emit = 1'b0;
    end_flag = 1'b0;
    out_byte = 8'd0;
    out_offset = 16'd0;
    out_status = STATUS_GOOD;
    if (take) begin
      unique case (phase)
        PH_SYNC2: begin
          if (b == regs.sync_second) begin
            phase_next = PH_ID;
          end else if (b == regs.sync_first) begin
            phase_next = PH_SYNC2;
          end else begin
            phase_next = PH_SYNC1;
          end
        end
        PH_ID: begin
          held_message_id_next = b;
          running_xor_next = b;
          phase_next = PH_LEN_HI;
        end
        PH_LEN_HI: begin
          expected_length_next = {b, 8'd0};
          running_xor_next = running_xor ^ b;
          phase_next = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          expected_length_next = full_length;
          running_xor_next = running_xor ^ b;
          bytes_seen_next = 16'd0;
          if (full_length > regs.max_payload_length) begin
            phase_next = PH_SYNC1;
            emit = 1'b1;
            end_flag = 1'b1;
            out_status = STATUS_OVER;
          end else if (full_length == 16'd0) begin
            phase_next = PH_CHECK;
          end else begin
            phase_next = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          emit = 1'b1;
          out_byte = b;
          out_offset = bytes_seen;
          running_xor_next = running_xor ^ b;
          bytes_seen_next = seen_inc;
          if (seen_inc >= expected_length) begin
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          phase_next = PH_SYNC1;
          emit = 1'b1;
          end_flag = 1'b1;
          out_status = (running_xor == b) ? STATUS_GOOD : STATUS_BAD;
        end
        default: begin
          phase_next = (b == regs.sync_first) ? PH_SYNC2 : PH_SYNC1;
        end
      endcase
    end
    if (take) begin
      out_valid_next = emit;
    end else if (res.ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_SYNC1;
      held_message_id <= 8'd0;
      expected_length <= 16'd0;
      bytes_seen <= 16'd0;
      running_xor <= 8'd0;
      res.valid <= 1'b0;
    end else begin
      phase <= phase_next;
      held_message_id <= held_message_id_next;
      expected_length <= expected_length_next;
      bytes_seen <= bytes_seen_next;
      running_xor <= running_xor_next;
      res.valid <= out_valid_next;
    end
    if (take && emit) begin
      res.is_frame_end <= end_flag;
      res.payload_byte <= out_byte;
      res.payload_offset <= out_offset;
      res.message_id <= held_message_id_next;
      res.frame_class <= class_of(held_message_id_next, regs);
      res.frame_status <= out_status;
    end
  end

endmodule

// ===== src/sync_length_xor_frame_receiver_unit.sv =====
// A byte that yields a result word passes the input and result registers.
// Throughput is one byte per cycle while the sink takes results; the input
// and result registers let a new byte enter while a result waits for the sink.
// Reset is synchronous and active high; it restores the sync hunt, clears the
// pipeline and sets the maximum payload length register to 252.
module sync_length_xor_frame_receiver_unit (
  input  logic             clk,
  input  logic             rst,
  slxfr_byte_if.sink       rx,
  slxfr_result_if.source   res,
  slxfr_cfg_if.sink        cfg
);
  import slxfr_pkg::*;

  cfg_t       regs;
  byte_word_t word;
  logic       take;

  slxfr_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  slxfr_in_stage u_in_stage (
    .clk  (clk),
    .rst  (rst),
    .rx   (rx),
    .take (take),
    .word (word)
  );

  slxfr_parser u_parser (
    .clk  (clk),
    .rst  (rst),
    .regs (regs),
    .word (word),
    .take (take),
    .res  (res)
  );

endmodule
